/* hdl/salc_pkg.sv */
// Shared types and constants of the set-associative LRU cache lookup block.
package salc_pkg;

	// Field widths fixed by the access and result formats.
	localparam int ADDR_W = 48;
	localparam int CNT_W = 48;
	localparam int OFFSET_W = 4;
	localparam int WAY_FIELD_W = 2;

	// Block size exponent after reset (64-byte blocks).
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;

	// Access kinds.
	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// One access.
	typedef struct packed {
		logic op;
		logic [ADDR_W-1:0] address;
	} req_t;

	// One lookup result with the counter values after this access.
	typedef struct packed {
		logic hit;
		logic [WAY_FIELD_W-1:0] way_used;
		logic [CNT_W-1:0] read_hits;
		logic [CNT_W-1:0] read_misses;
		logic [CNT_W-1:0] write_hits;
		logic [CNT_W-1:0] write_misses;
	} rsp_t;

endpackage

/* hdl/salc_lookup.sv */
// Tag compare, victim choice and LRU rank update for one set row.
module salc_lookup #(
	parameter int WAYS = 4,
	parameter int TAG_W = 35,
	parameter int WAY_W = 2
) (
	input  logic [WAYS*TAG_W-1:0] tags,
	input  logic [WAYS-1:0]       valid,
	input  logic [WAYS*WAY_W-1:0] ranks,
	input  logic [TAG_W-1:0]      tag,
	output logic                  hit,
	output logic [WAY_W-1:0]      way,
	output logic [WAYS*TAG_W-1:0] tags_n,
	output logic [WAYS-1:0]       valid_n,
	output logic [WAYS*WAY_W-1:0] ranks_n
);

	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] old_rank;
	logic             any_free;

	// Find the lowest matching way, the lowest free way and the least recent way.
	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		any_free = 1'b0;
		free_way = '0;
		lru_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid[w] && (tags[w*TAG_W +: TAG_W] == tag)) begin
				hit = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid[w]) begin
				any_free = 1'b1;
				free_way = WAY_W'(w);
			end
			if (ranks[w*WAY_W +: WAY_W] == WAY_W'(WAYS - 1)) begin
				lru_way = WAY_W'(w);
			end
		end
		if (hit) begin
			way = hit_way;
		end else if (any_free) begin
			way = free_way;
		end else begin
			way = lru_way;
		end
	end

	// Move the chosen way to the front; ways ahead of it age by one.
	always_comb begin
		logic [WAY_W-1:0] rk;
		old_rank = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == way) begin
				old_rank = ranks[w*WAY_W +: WAY_W];
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			rk = ranks[w*WAY_W +: WAY_W];
			if (WAY_W'(w) == way) begin
				rk = '0;
			end else if (rk < old_rank) begin
				rk = rk + 1'b1;
			end
			ranks_n[w*WAY_W +: WAY_W] = rk;
		end
	end

	// A miss installs the tag in the chosen way and marks it valid.
	always_comb begin
		tags_n = tags;
		valid_n = valid;
		if (!hit) begin
			for (int w = 0; w < WAYS; w++) begin
				if (WAY_W'(w) == way) begin
					tags_n[w*TAG_W +: TAG_W] = tag;
					valid_n[w] = 1'b1;
				end
			end
		end
	end

endmodule

/* hdl/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative cache lookup model with LRU replacement.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  salc_pkg::req_t (op, address)
//   rsp      out        rsp_valid / rsp_ready  salc_pkg::rsp_t (hit, way, counters)
//   cfg      in         cfg_we                 cfg_wdata: offset bits
//
// One access per cycle is sustained while results are taken; a result is registered after its
// access transfers (memory read stage, then lookup and write-back into the output register).
// A back-to-back access to the same set takes the just-written row from a forwarding register.
// After reset a clearing pass over all SETS rows initializes valid bits and LRU ranks;
// req_ready stays low during it. A stalled result holds the lookup stage and drops req_ready.
// SETS must be a power of two.
module set_assoc_lru_cache_sim #(
	parameter int SETS = 8192,
	parameter int WAYS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  salc_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output salc_pkg::rsp_t                    rsp,
	input  logic                              cfg_we,
	input  logic [salc_pkg::OFFSET_W-1:0]     cfg_wdata
);

	import salc_pkg::*;

	localparam int LOG2_SETS = $clog2(SETS);
	localparam int SET_W = (LOG2_SETS > 0) ? LOG2_SETS : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_W = ADDR_W - LOG2_SETS;
	localparam int TROW_W = WAYS * TAG_W;
	localparam int RANK_ROW_W = WAYS * WAY_W;
	localparam int MROW_W = WAYS + RANK_ROW_W;
	localparam int CLR_W = LOG2_SETS + 1;

	// Tag rows are left unset after reset; metadata rows are cleared by a pass.
	logic [TROW_W-1:0] tag_mem [SETS];
	logic [MROW_W-1:0] meta_mem [SETS];

	logic [OFFSET_W-1:0] offset_q;
	logic [CLR_W-1:0]    clr_cnt_q;
	logic                clearing;
	logic [MROW_W-1:0]   clr_row;

	logic [ADDR_W-1:0]   block;
	logic [SET_W-1:0]    req_set;
	logic [TAG_W-1:0]    req_tag;
	logic                req_xfer;

	logic                s1_valid;
	logic                s1_fire;
	logic                op_s1;
	logic [SET_W-1:0]    set_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic [TROW_W-1:0]   tag_rd_s1;
	logic [MROW_W-1:0]   meta_rd_s1;
	logic                fwd_s1;
	logic [TROW_W-1:0]   fwd_tags_s1;
	logic [MROW_W-1:0]   fwd_meta_s1;

	logic [TROW_W-1:0]   cur_tags;
	logic [MROW_W-1:0]   cur_meta;
	logic                lk_hit;
	logic [WAY_W-1:0]    lk_way;
	logic [TROW_W-1:0]   new_tags;
	logic [WAYS-1:0]     new_valid;
	logic [RANK_ROW_W-1:0] new_ranks;
	logic [WAYS-1:0]     lru_flags;

	logic                meta_we;
	logic [SET_W-1:0]    wr_set;
	logic [MROW_W-1:0]   wr_meta;

	logic [CNT_W-1:0]    rd_hit_q;
	logic [CNT_W-1:0]    rd_miss_q;
	logic [CNT_W-1:0]    wr_hit_q;
	logic [CNT_W-1:0]    wr_miss_q;
	logic [CNT_W-1:0]    rd_hit_n;
	logic [CNT_W-1:0]    rd_miss_n;
	logic [CNT_W-1:0]    wr_hit_n;
	logic [CNT_W-1:0]    wr_miss_n;
	logic [WAY_W+1:0]    way_ext;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// Block size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// Clearing pass counter; it stops once every set has been written.
	assign clearing = (clr_cnt_q != CLR_W'(SETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Reset row: nothing valid, way w holds rank w.
	always_comb begin
		clr_row = '0;
		for (int w = 0; w < WAYS; w++) begin
			clr_row[w*WAY_W +: WAY_W] = WAY_W'(w);
		end
	end

	// Split the block number into set index and tag.
	assign block = req.address >> offset_q;
	assign req_set = (SETS > 1) ? block[SET_W-1:0] : '0;
	assign req_tag = TAG_W'(block >> LOG2_SETS);

	// Lookup stage advances when the output register is free or being emptied.
	assign s1_fire = s1_valid && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clearing && (!s1_valid || s1_fire);
	assign req_xfer = req_valid && req_ready;

	// Metadata write port: clearing pass or write-back from the lookup stage.
	always_comb begin
		meta_we = clearing || s1_fire;
		if (clearing) begin
			wr_set = clr_cnt_q[SET_W-1:0];
			wr_meta = clr_row;
		end else begin
			wr_set = set_s1;
			wr_meta = {new_valid, new_ranks};
		end
	end

	// Tag memory: read on a transfer, write back the row of the item leaving the stage.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			tag_mem[set_s1] <= new_tags;
		end
		if (req_xfer) begin
			tag_rd_s1 <= tag_mem[req_set];
		end
	end

	// Metadata memory: valid bits and LRU ranks of one set per row.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_set] <= wr_meta;
		end
		if (req_xfer) begin
			meta_rd_s1 <= meta_mem[req_set];
		end
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (req_xfer) begin
				s1_valid <= 1'b1;
				fwd_s1 <= s1_fire && (set_s1 == req_set);
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// Lookup stage payload, including the row written in the same cycle as the read.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1 <= req.op;
			set_s1 <= req_set;
			tag_s1 <= req_tag;
			fwd_tags_s1 <= new_tags;
			fwd_meta_s1 <= wr_meta;
		end
	end

	assign cur_tags = fwd_s1 ? fwd_tags_s1 : tag_rd_s1;
	assign cur_meta = fwd_s1 ? fwd_meta_s1 : meta_rd_s1;

	salc_lookup #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W),
		.WAY_W (WAY_W)
	) u_lookup (
		.tags    (cur_tags),
		.valid   (cur_meta[MROW_W-1 -: WAYS]),
		.ranks   (cur_meta[RANK_ROW_W-1:0]),
		.tag     (tag_s1),
		.hit     (lk_hit),
		.way     (lk_way),
		.tags_n  (new_tags),
		.valid_n (new_valid),
		.ranks_n (new_ranks)
	);

	// Saturating counter updates for the access in the lookup stage.
	always_comb begin
		rd_hit_n = rd_hit_q;
		rd_miss_n = rd_miss_q;
		wr_hit_n = wr_hit_q;
		wr_miss_n = wr_miss_q;
		case ({op_s1, lk_hit})
			{OP_READ, 1'b1}: rd_hit_n = (&rd_hit_q) ? rd_hit_q : rd_hit_q + 1'b1;
			{OP_READ, 1'b0}: rd_miss_n = (&rd_miss_q) ? rd_miss_q : rd_miss_q + 1'b1;
			{OP_WRITE, 1'b1}: wr_hit_n = (&wr_hit_q) ? wr_hit_q : wr_hit_q + 1'b1;
			default: wr_miss_n = (&wr_miss_q) ? wr_miss_q : wr_miss_q + 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_q <= '0;
			rd_miss_q <= '0;
			wr_hit_q <= '0;
			wr_miss_q <= '0;
		end else if (s1_fire) begin
			rd_hit_q <= rd_hit_n;
			rd_miss_q <= rd_miss_n;
			wr_hit_q <= wr_hit_n;
			wr_miss_q <= wr_miss_n;
		end
	end

	// Output register.
	assign way_ext = {2'b00, lk_way};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_q.hit <= lk_hit;
			rsp_q.way_used <= way_ext[WAY_FIELD_W-1:0];
			rsp_q.read_hits <= rd_hit_n;
			rsp_q.read_misses <= rd_miss_n;
			rsp_q.write_hits <= wr_hit_n;
			rsp_q.write_misses <= wr_miss_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Ways holding the least recent rank in the row under lookup.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			lru_flags[w] = (cur_meta[w*WAY_W +: WAY_W] == WAY_W'(WAYS - 1));
		end
	end

	// No access may transfer while the metadata is still being cleared.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req_ready)
		else $error("access accepted during clearing pass");

	// Ranks in a set stay a permutation, so exactly one way is least recent.
	a_one_lru: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> $onehot(lru_flags))
		else $error("LRU ranks of a set are not a permutation");

	// A lookup leaving the stage always produces a result next cycle.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid_q)
		else $error("lookup retired without a result");

	// A stalled lookup stays in place and is not written back.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_fire) |=> (s1_valid && $stable(set_s1) && $stable(tag_s1)))
		else $error("stalled lookup stage changed");

	// A hit leaves the valid bits of the row that was read unchanged.
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && lk_hit) |-> new_valid == cur_meta[MROW_W-1 -: WAYS])
		else $error("hit changed the valid bits");

endmodule
